### rtl/rlc_pkg.sv
// ----------------------------------------------------------------------------
// rlc_pkg
// Shared types and codes of the reference-counted object cache.
// ----------------------------------------------------------------------------
package rlc_pkg;

  localparam int unsigned DevW = 32;
  localparam int unsigned InoW = 32;
  localparam int unsigned RefW = 16;
  localparam int unsigned LinkW = 16;
  localparam int unsigned SlotW = 6;
  localparam int unsigned StatW = 2;

  localparam logic [RefW-1:0] RefMax = '1;

  localparam logic [StatW-1:0] StatOk = 2'd0;
  localparam logic [StatW-1:0] StatNoFree = 2'd1;
  localparam logic [StatW-1:0] StatPutErr = 2'd2;

  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;

  typedef enum logic [3:0] {
    StInit,
    StIdle,
    StScan,
    StScanLast,
    StPick,
    StPutRd,
    StPutWr,
    StRank,
    StRankWr,
    StOut
  } state_e;

endpackage

### rtl/refcounted_lru_object_cache_core.sv
// ----------------------------------------------------------------------------
// refcounted_lru_object_cache_core
// Object cache keyed by device and inode with reference counts and LRU reuse.
// ----------------------------------------------------------------------------
//  Channel | Direction | Signals
//  in      | input     | in_valid_i, in_ready_o, op_i .. release_page_i
//  out     | output    | out_valid_o, out_ready_i, slot_out_o .. ref_after_o
//
// After reset an initialisation pass writes every entry, with no item taken.
// A get sweeps the single memory port once, comparing keys and tracking
// the least recent unreferenced entry. A put reads its entry and, unless
// that is an error, rewrites it; when the entry moves to most recent, every
// rank is then read and rewritten in turn. One item is held at a time; the
// next is taken once the result has been handed over.
module refcounted_lru_object_cache_core
  import rlc_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             op_i,
  input  logic [DevW-1:0]  device_i,
  input  logic [InoW-1:0]  inode_number_i,
  input  logic             want_page_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [LinkW-1:0] links_i,
  input  logic             release_page_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [SlotW-1:0] slot_out_o,
  output logic             hit_o,
  output logic [StatW-1:0] status_o,
  output logic             alloc_page_o,
  output logic             free_page_o,
  output logic [RefW-1:0]  ref_after_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned EW = DevW + InoW + RefW + 2 + AW;
  localparam logic [AW-1:0] Last = AW'(ENTRIES - 1);

  typedef struct packed {
    logic [DevW-1:0] dev;
    logic [InoW-1:0] ino;
    logic [RefW-1:0] cnt;
    logic            pg;
    logic            own;
    logic [AW-1:0]   rank;
  } entry_t;

  state_e state_q, state_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [AW-1:0] prev_q, prev_d;
  logic op_q;
  logic [DevW-1:0] dev_q;
  logic [InoW-1:0] ino_q;
  logic want_q, rel_q;
  logic [SlotW-1:0] slot_q;
  logic [LinkW-1:0] links_q;
  logic found_q, found_d;
  logic [AW-1:0] fidx_q, fidx_d;
  logic pfound_q, pfound_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic [AW-1:0] prank_q, prank_d;
  logic [AW-1:0] vrank_q, vrank_d;
  logic ov_q, ov_d;
  logic [SlotW-1:0] o_slot_q, o_slot_d;
  logic o_hit_q, o_hit_d, o_alloc_q, o_alloc_d, o_free_q, o_free_d;
  logic [StatW-1:0] o_stat_q, o_stat_d;
  logic [RefW-1:0] o_ref_q, o_ref_d;

  logic we;
  logic [AW-1:0] addr;
  entry_t wdata, rdata;
  logic [EW-1:0] rraw;
  logic rvalid;
  logic [AW-1:0] ridx;
  logic slot_ok;
  logic take;

  rlc_ram #(.Width(EW), .Depth(ENTRIES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rraw)
  );
  assign rdata = entry_t'(rraw);

  assign slot_ok = (32'(slot_q) < 32'(ENTRIES));
  assign take = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StInit:     if (idx_q == Last) state_d = StIdle;
      StIdle:     if (take) state_d = (op_i == OpGet) ? StScan : StPutRd;
      StScan:     if (idx_q == Last) state_d = StScanLast;
      StScanLast: state_d = StPick;
      StPick:     state_d = StOut;
      StPutRd:    state_d = slot_ok ? StPutWr : StOut;
      StPutWr:    state_d = (rdata.cnt == RefW'(1) && links_q == '0) ? StRank : StOut;
      StRank:     state_d = StRankWr;
      StRankWr:   state_d = (idx_q == Last) ? StOut : StRank;
      StOut:      if (!ov_q) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    idx_d = idx_q;
    prev_d = prev_q;
    we = 1'b0;
    addr = idx_q;
    wdata = rdata;
    found_d = found_q;
    fidx_d = fidx_q;
    pfound_d = pfound_q;
    pidx_d = pidx_q;
    prank_d = prank_q;
    vrank_d = vrank_q;
    ov_d = ov_q;
    o_slot_d = o_slot_q;
    o_hit_d = o_hit_q;
    o_stat_d = o_stat_q;
    o_alloc_d = o_alloc_q;
    o_free_d = o_free_q;
    o_ref_d = o_ref_q;
    rvalid = (state_q == StScan && idx_q != '0) || state_q == StScanLast;
    ridx = prev_q;
    unique case (state_q)
      StInit: begin
        we = 1'b1;
        wdata = '0;
        wdata.rank = idx_q;
        idx_d = (idx_q == Last) ? '0 : idx_q + 1'b1;
      end
      StIdle: begin
        idx_d = '0;
        found_d = 1'b0;
        pfound_d = 1'b0;
      end
      StScan, StScanLast: begin
        prev_d = idx_q;
        if (state_q == StScan) idx_d = (idx_q == Last) ? '0 : idx_q + 1'b1;
        if (rvalid) begin
          if (!found_q && rdata.dev == dev_q && rdata.ino == ino_q) begin
            found_d = 1'b1;
            fidx_d = ridx;
          end
          if (rdata.cnt == '0 && (!pfound_q || rdata.rank < prank_q)) begin
            pfound_d = 1'b1;
            pidx_d = ridx;
            prank_d = rdata.rank;
          end
        end
        if (state_q == StScanLast) addr = found_d ? fidx_d : pidx_d;
      end
      StPick: begin
        addr = found_q ? fidx_q : pidx_q;
        ov_d = 1'b1;
        o_hit_d = 1'b0;
        o_stat_d = StatOk;
        o_alloc_d = 1'b0;
        o_free_d = 1'b0;
        if (found_q) begin
          we = 1'b1;
          o_hit_d = 1'b1;
          o_slot_d = SlotW'(fidx_q);
          if (rdata.cnt != '0) begin
            wdata.cnt = (rdata.cnt == RefMax) ? rdata.cnt : rdata.cnt + 1'b1;
          end else begin
            wdata.cnt = RefW'(1);
            if (!rdata.pg && want_q) begin
              wdata.pg = 1'b1;
              wdata.own = 1'b1;
              o_alloc_d = 1'b1;
            end
          end
          o_ref_d = wdata.cnt;
        end else if (pfound_q) begin
          we = 1'b1;
          o_slot_d = SlotW'(pidx_q);
          if (rdata.dev != dev_q) begin
            o_free_d = rdata.own && rdata.pg;
            wdata.pg = 1'b0;
            wdata.own = 1'b0;
          end
          wdata.dev = dev_q;
          wdata.ino = ino_q;
          wdata.cnt = RefW'(1);
          if (!wdata.pg && want_q) begin
            wdata.pg = 1'b1;
            wdata.own = 1'b1;
            o_alloc_d = 1'b1;
          end
          o_ref_d = RefW'(1);
        end else begin
          o_slot_d = '0;
          o_stat_d = StatNoFree;
          o_ref_d = '0;
        end
      end
      StPutRd: begin
        addr = AW'(slot_q);
        if (!slot_ok) begin
          ov_d = 1'b1;
          o_slot_d = slot_q;
          o_hit_d = 1'b0;
          o_stat_d = StatPutErr;
          o_alloc_d = 1'b0;
          o_free_d = 1'b0;
          o_ref_d = '0;
        end
      end
      StPutWr: begin
        addr = AW'(slot_q);
        o_slot_d = slot_q;
        o_hit_d = 1'b0;
        o_alloc_d = 1'b0;
        o_free_d = 1'b0;
        idx_d = '0;
        vrank_d = rdata.rank;
        if (rdata.cnt == '0) begin
          ov_d = 1'b1;
          o_stat_d = StatPutErr;
          o_ref_d = '0;
        end else begin
          we = 1'b1;
          o_stat_d = StatOk;
          wdata.cnt = rdata.cnt - 1'b1;
          o_ref_d = wdata.cnt;
          if (rdata.cnt == RefW'(1) && links_q == '0) begin
            o_free_d = rel_q && rdata.pg;
            wdata.pg = 1'b0;
            wdata.own = 1'b0;
          end else begin
            ov_d = 1'b1;
          end
        end
      end
      StRank: ;
      StRankWr: begin
        we = 1'b1;
        if (idx_q == AW'(slot_q)) wdata.rank = AW'(ENTRIES - 1);
        else if (rdata.rank > vrank_q) wdata.rank = rdata.rank - 1'b1;
        idx_d = (idx_q == Last) ? '0 : idx_q + 1'b1;
        if (idx_q == Last) ov_d = 1'b1;
      end
      StOut: begin
        if (out_ready_i) ov_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      idx_q <= '0;
      ov_q <= 1'b0;
      found_q <= 1'b0;
      pfound_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      ov_q <= ov_d;
      found_q <= found_d;
      pfound_q <= pfound_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    fidx_q <= fidx_d;
    pidx_q <= pidx_d;
    prank_q <= prank_d;
    vrank_q <= vrank_d;
    o_slot_q <= o_slot_d;
    o_hit_q <= o_hit_d;
    o_stat_q <= o_stat_d;
    o_alloc_q <= o_alloc_d;
    o_free_q <= o_free_d;
    o_ref_q <= o_ref_d;
    if (take) begin
      op_q <= op_i;
      dev_q <= device_i;
      ino_q <= inode_number_i;
      want_q <= want_page_i;
      slot_q <= slot_i;
      links_q <= links_i;
      rel_q <= release_page_i;
    end
  end

  assign out_valid_o = ov_q && (state_q == StOut);
  assign slot_out_o = o_slot_q;
  assign hit_o = o_hit_q;
  assign status_o = o_stat_q;
  assign alloc_page_o = o_alloc_q;
  assign free_page_o = o_free_q;
  assign ref_after_o = o_ref_q;

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("item taken while result pending");
  a_hit_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && hit_o) |-> (status_o == StatOk && op_q == OpGet))
    else $error("hit with bad status");
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != StatOk) |-> (ref_after_o == '0 && !alloc_page_o))
    else $error("error result carries data");

endmodule

### rtl/rlc_ram.sv
// ----------------------------------------------------------------------------
// rlc_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module rlc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

### tb/tb_rlc_checker.sv
// ----------------------------------------------------------------------------
// tb_rlc_checker
// Watches both channels of the object cache, predicts each result from a
// private copy of the table and compares every field of the result items.
// ----------------------------------------------------------------------------
module tb_rlc_checker
  import rlc_pkg::*;
#(
  parameter int unsigned ENTRIES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  logic             op_i,
  input  logic [DevW-1:0]  device_i,
  input  logic [InoW-1:0]  inode_number_i,
  input  logic             want_page_i,
  input  logic [SlotW-1:0] slot_i,
  input  logic [LinkW-1:0] links_i,
  input  logic             release_page_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  logic [SlotW-1:0] slot_out_i,
  input  logic             hit_i,
  input  logic [StatW-1:0] status_i,
  input  logic             alloc_page_i,
  input  logic             free_page_i,
  input  logic [RefW-1:0]  ref_after_i,
  output int               fail_count_o,
  output int               pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SlotW-1:0] slot;
    logic             hit;
    logic [StatW-1:0] status;
    logic             alloc;
    logic             freep;
    logic [RefW-1:0]  refs;
  } cache_result_t;

  logic [DevW-1:0] dev_tab [ENTRIES];
  logic [InoW-1:0] ino_tab [ENTRIES];
  logic [RefW-1:0] ref_tab [ENTRIES];
  logic            page_tab [ENTRIES];
  logic            owned_tab [ENTRIES];
  int unsigned     rank_tab [ENTRIES];
  cache_result_t   expected_q [$];

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic cache_result_t predict_cache(
      input logic op, input logic [DevW-1:0] dev, input logic [InoW-1:0] ino,
      input logic want, input logic [SlotW-1:0] slot,
      input logic [LinkW-1:0] links, input logic rel);
    cache_result_t r;
    int pick;
    int unsigned old_rank;
    r = '0;
    if (op == OpGet) begin
      for (int i = 0; i < ENTRIES; i++) begin
        if (dev_tab[i] == dev && ino_tab[i] == ino) begin
          if (ref_tab[i] != 0) begin
            if (ref_tab[i] != RefMax) ref_tab[i]++;
          end else begin
            ref_tab[i] = RefW'(1);
            if (!page_tab[i] && want) begin
              page_tab[i] = 1'b1;
              owned_tab[i] = 1'b1;
              r.alloc = 1'b1;
            end
          end
          r.slot = SlotW'(i);
          r.hit = 1'b1;
          r.refs = ref_tab[i];
          return r;
        end
      end
      pick = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (ref_tab[i] == 0 && (pick < 0 || rank_tab[i] < rank_tab[pick])) pick = i;
      if (pick < 0) begin
        r.status = StatNoFree;
        return r;
      end
      if (dev_tab[pick] != dev) begin
        r.freep = owned_tab[pick] && page_tab[pick];
        page_tab[pick] = 1'b0;
        owned_tab[pick] = 1'b0;
      end
      dev_tab[pick] = dev;
      ino_tab[pick] = ino;
      ref_tab[pick] = RefW'(1);
      if (!page_tab[pick] && want) begin
        page_tab[pick] = 1'b1;
        owned_tab[pick] = 1'b1;
        r.alloc = 1'b1;
      end
      r.slot = SlotW'(pick);
      r.refs = RefW'(1);
    end else begin
      r.slot = slot;
      if (slot >= ENTRIES || ref_tab[slot] == 0) begin
        r.status = StatPutErr;
        return r;
      end
      if (ref_tab[slot] == 1 && links == 0) begin
        ref_tab[slot] = '0;
        r.freep = rel && page_tab[slot];
        page_tab[slot] = 1'b0;
        owned_tab[slot] = 1'b0;
        old_rank = rank_tab[slot];
        for (int i = 0; i < ENTRIES; i++)
          if (rank_tab[i] > old_rank) rank_tab[i]--;
        rank_tab[slot] = ENTRIES - 1;
      end else begin
        ref_tab[slot]--;
      end
      r.refs = ref_tab[slot];
    end
    return r;
  endfunction

  assign pending_o = expected_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cache_result_t exp_r;
    cache_result_t got;
    if (!rst_ni) begin
      fail_count_o = 0;
      expected_q.delete();
      for (int i = 0; i < ENTRIES; i++) begin
        dev_tab[i] = '0;
        ino_tab[i] = '0;
        ref_tab[i] = '0;
        page_tab[i] = 1'b0;
        owned_tab[i] = 1'b0;
        rank_tab[i] = i;
      end
    end else begin
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_cache(op_i, device_i, inode_number_i,
                                           want_page_i, slot_i, links_i,
                                           release_page_i));
      if (out_valid_i && out_ready_i) begin
        got = '{slot_out_i, hit_i, status_i, alloc_page_i, free_page_i, ref_after_i};
        if (expected_q.size() == 0) begin
          report_mismatch("result item with nothing expected");
        end else begin
          exp_r = expected_q.pop_front();
          if (got.slot !== exp_r.slot)
            report_mismatch($sformatf("slot_out %0d, expected %0d", got.slot, exp_r.slot));
          if (got.hit !== exp_r.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", got.hit, exp_r.hit));
          if (got.status !== exp_r.status)
            report_mismatch($sformatf("status %0d, expected %0d", got.status,
                                      exp_r.status));
          if (got.alloc !== exp_r.alloc)
            report_mismatch($sformatf("alloc_page %0b, expected %0b", got.alloc,
                                      exp_r.alloc));
          if (got.freep !== exp_r.freep)
            report_mismatch($sformatf("free_page %0b, expected %0b", got.freep,
                                      exp_r.freep));
          if (got.refs !== exp_r.refs)
            report_mismatch($sformatf("ref_after %0d, expected %0d", got.refs,
                                      exp_r.refs));
        end
      end
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the object cache: directed corner cases, then random gets and
// puts over a small key pool, with random gaps, stalls and one long hold-off.
// ----------------------------------------------------------------------------
module tb;

  import rlc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ENTRIES = 64;

  logic             clk = 0;
  logic             rst_n = 0;
  logic             in_valid = 0;
  logic             in_ready;
  logic             op = OpGet;
  logic [DevW-1:0]  device = '0;
  logic [InoW-1:0]  inode_number = '0;
  logic             want_page = 0;
  logic [SlotW-1:0] slot = '0;
  logic [LinkW-1:0] links = '0;
  logic             release_page = 0;
  logic             out_valid;
  logic             out_ready = 0;
  logic [SlotW-1:0] slot_out;
  logic             hit;
  logic [StatW-1:0] status;
  logic             alloc_page;
  logic             free_page;
  logic [RefW-1:0]  ref_after;
  int               fail_count;
  int               pending;
  bit               calm = 0;
  bit               hold_off = 0;

  always #5 clk = ~clk;

  refcounted_lru_object_cache_core #(.ENTRIES(ENTRIES)) i_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .op_i(op), .device_i(device), .inode_number_i(inode_number),
    .want_page_i(want_page), .slot_i(slot), .links_i(links),
    .release_page_i(release_page),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .slot_out_o(slot_out), .hit_o(hit), .status_o(status),
    .alloc_page_o(alloc_page), .free_page_o(free_page), .ref_after_o(ref_after)
  );

  tb_rlc_checker #(.ENTRIES(ENTRIES)) i_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .op_i(op), .device_i(device), .inode_number_i(inode_number),
    .want_page_i(want_page), .slot_i(slot), .links_i(links),
    .release_page_i(release_page),
    .out_valid_i(out_valid), .out_ready_i(out_ready),
    .slot_out_i(slot_out), .hit_i(hit), .status_i(status),
    .alloc_page_i(alloc_page), .free_page_i(free_page), .ref_after_i(ref_after),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= calm || ($urandom_range(99) >= 26);
  end

  task automatic send_item(input logic o, input logic [DevW-1:0] d,
                           input logic [InoW-1:0] n, input logic w,
                           input logic [SlotW-1:0] s, input logic [LinkW-1:0] l,
                           input logic r);
    while (!calm && $urandom_range(99) < 26) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    op <= o;
    device <= d;
    inode_number <= n;
    want_page <= w;
    slot <= s;
    links <= l;
    release_page <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_get(input logic [DevW-1:0] d, input logic [InoW-1:0] n,
                          input logic w);
    send_item(OpGet, d, n, w, SlotW'($urandom), LinkW'($urandom), 1'($urandom));
  endtask

  task automatic send_put(input logic [SlotW-1:0] s, input logic [LinkW-1:0] l,
                          input logic r);
    send_item(OpPut, $urandom, $urandom, 1'($urandom), s, l, r);
  endtask

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned k;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    send_get('0, '0, 1);
    send_get('0, '0, 0);
    send_put(0, 1, 1);
    send_put(0, 0, 1);
    send_put(0, 0, 1);
    send_put(63, '1, 1);
    send_get('1, '1, 1);
    send_get('1, 32'h1234, 0);
    send_put(1, 0, 0);
    send_get('1, '1, 1);
    send_get(32'h5, 32'h7, 1);
    send_put(0, 0, 1);
    send_get(32'hAAAA_5555, 32'h5555_AAAA, 1);
    send_put(63, 0, 0);
    fork
      begin
        hold_off = 1;
        repeat (300) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 70; i++) send_get(i, 32'hF000 + i, 1'($urandom));
    join
    for (int i = 0; i < 64; i++) send_put(SlotW'(i), '1, 1);
    for (int i = 0; i < 64; i++) send_put(SlotW'(i), 0, 1'($urandom));
    for (int i = 0; i < 800; i++) begin
      calm = (i >= 300 && i < 400);
      k = $urandom_range(99);
      if (k < 50)
        send_get($urandom_range(3), $urandom_range(40), 1'($urandom));
      else if (k < 90)
        send_put(SlotW'($urandom_range(ENTRIES - 1)),
                 ($urandom_range(3) == 0) ? LinkW'($urandom) : LinkW'(0),
                 1'($urandom));
      else if (k < 95)
        send_get($urandom, $urandom, 1'($urandom));
      else
        send_item(OpGet, 0, 0, 0, 0, 0, 0);
    end
    in_valid <= 0;
    calm = 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
